// File: sv/xrg_pkg.sv
// shared constants, codes and controller/datapath command types for the xorshift generator
package xrg_pkg;

  localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam logic [63:0] OUT_MUL    = 64'h2545F4914F6CDD1D;
  localparam logic [63:0] SEED_RESET = 64'd42;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // action codes of an input item
  localparam logic [1:0] ACT_RESEED  = 2'd0;
  localparam logic [1:0] ACT_RAW     = 2'd1;
  localparam logic [1:0] ACT_UNIFORM = 2'd2;
  localparam logic [1:0] ACT_BELOW   = 2'd3;

  // splitmix64 round, evaluated at elaboration only for the reset state
  function automatic logic [63:0] mix64(input logic [63:0] v);
    logic [63:0] z;
    z = v + MIX_GOLDEN;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    z = z ^ (z >> 31);
    return (z == 64'd0) ? 64'd1 : z;
  endfunction

  localparam logic [63:0] GEN_RESET = mix64(SEED_RESET);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MIX_A,
    OP_MIX_B,
    OP_MIX_END,
    OP_ADVANCE,
    OP_MUL,
    OP_DIV_LOAD_ONES,
    OP_DIV_LOAD_ACC,
    OP_DIV_STEP,
    OP_SET_LIMIT
  } op_e;

  typedef enum logic [1:0] {
    MC_MIX_A,
    MC_MIX_B,
    MC_OUT
  } mul_const_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RAW,
    RES_FRAC,
    RES_REM
  } res_sel_e;

  typedef struct packed {
    op_e        op;
    mul_const_e mc;
    logic [1:0] mul_phase;
    logic       load_bound;
    logic       out_load;
    res_sel_e   res_sel;
    logic       bad;
  } cmd_t;

  typedef struct packed {
    logic bound_zero;
    logic below_limit;
  } status_t;

endpackage

// File: sv/xrg_if.sv
// valid/ready stream interfaces for the request and result channels
interface xrg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] bound;

  modport source (output valid, output action, output bound, input ready);
  modport sink   (input valid, input action, input bound, output ready);
endinterface

interface xrg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        bad_bound;

  modport source (output valid, output value, output bad_bound, input ready);
  modport sink   (input valid, input value, input bad_bound, output ready);
endinterface

// File: sv/xrg_datapath.sv
// generator state, seed register, shared 32x32 multiplier, serial divider and result register
module xrg_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [63:0]      cfg_data_i,
  input  logic [63:0]      in_bound_i,
  input  xrg_pkg::cmd_t    cmd_i,
  output xrg_pkg::status_t status_o,
  output logic [63:0]      out_value_o,
  output logic             out_bad_o
);

  logic [63:0] state_q, state_d;
  logic [63:0] seed_q;
  logic [63:0] work_q, acc_q, prod_q, div_q, rem_q, limit_q, bound_q, value_q;
  logic        bad_q;

  logic [63:0] xs1, xs2, xs3;
  logic [63:0] mix_a_z, mix_a, mix_b, mix_end;
  logic [63:0] mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] div_t, div_diff;
  logic [63:0] res_val;

  // xorshift advance
  assign xs1 = state_q ^ (state_q >> 12);
  assign xs2 = xs1 ^ (xs1 << 25);
  assign xs3 = xs2 ^ (xs2 >> 27);

  // splitmix stages around the two multiplies
  assign mix_a_z = seed_q + xrg_pkg::MIX_GOLDEN;
  assign mix_a   = mix_a_z ^ (mix_a_z >> 30);
  assign mix_b   = acc_q ^ (acc_q >> 27);
  assign mix_end = acc_q ^ (acc_q >> 31);

  always_comb begin
    case (cmd_i.mc)
      xrg_pkg::MC_MIX_A: mul_k = xrg_pkg::MIX_MUL_A;
      xrg_pkg::MC_MIX_B: mul_k = xrg_pkg::MIX_MUL_B;
      default:           mul_k = xrg_pkg::OUT_MUL;
    endcase
  end

  // low 64 bits of work * k from three partial products
  always_comb begin
    case (cmd_i.mul_phase)
      2'd0:    begin mul_a = work_q[31:0];  mul_b = mul_k[31:0];  end
      2'd1:    begin mul_a = work_q[63:32]; mul_b = mul_k[31:0];  end
      default: begin mul_a = work_q[31:0];  mul_b = mul_k[63:32]; end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // restoring division step
  assign div_t    = {rem_q, div_q[63]};
  assign div_diff = div_t - {1'b0, bound_q};

  always_comb begin
    case (cmd_i.res_sel)
      xrg_pkg::RES_RAW:  res_val = acc_q;
      xrg_pkg::RES_FRAC: res_val = {11'd0, acc_q[63:11]};
      xrg_pkg::RES_REM:  res_val = rem_q;
      default:           res_val = 64'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (cmd_i.op == xrg_pkg::OP_ADVANCE) begin
      state_d = xs3;
    end else if (cmd_i.op == xrg_pkg::OP_MIX_END) begin
      state_d = (mix_end == 64'd0) ? 64'd1 : mix_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xrg_pkg::GEN_RESET;
      seed_q  <= xrg_pkg::SEED_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_bound) begin
      bound_q <= in_bound_i;
    end
    case (cmd_i.op)
      xrg_pkg::OP_MIX_A:   work_q <= mix_a;
      xrg_pkg::OP_MIX_B:   work_q <= mix_b;
      xrg_pkg::OP_ADVANCE: work_q <= xs3;
      xrg_pkg::OP_MUL: begin
        prod_q <= mul_p;
        case (cmd_i.mul_phase)
          2'd0:    acc_q <= acc_q;
          2'd1:    acc_q <= prod_q;
          default: acc_q <= acc_q + {prod_q[31:0], 32'd0};
        endcase
      end
      xrg_pkg::OP_DIV_LOAD_ONES: begin
        div_q <= '1;
        rem_q <= '0;
      end
      xrg_pkg::OP_DIV_LOAD_ACC: begin
        div_q <= acc_q;
        rem_q <= '0;
      end
      xrg_pkg::OP_DIV_STEP: begin
        div_q <= {div_q[62:0], 1'b0};
        rem_q <= div_diff[64] ? div_t[63:0] : div_diff[63:0];
      end
      xrg_pkg::OP_SET_LIMIT: limit_q <= ~rem_q;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      value_q <= res_val;
      bad_q   <= cmd_i.bad;
    end
  end

  assign status_o.bound_zero  = (bound_q == 64'd0);
  assign status_o.below_limit = (acc_q < limit_q);
  assign out_value_o = value_q;
  assign out_bad_o   = bad_q;

`ifndef SYNTHESIS
  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != 64'd0)
    else $error("generator state became zero");

  a_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == xrg_pkg::OP_DIV_STEP |=> rem_q < bound_q)
    else $error("remainder not below bound after division step");

  a_limit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == xrg_pkg::OP_SET_LIMIT |=> limit_q != 64'd0)
    else $error("rejection limit is zero");
`endif

endmodule

// File: sv/xrg_ctrl.sv
// sequencer for reseed, draw, rejection loop and result handshake
module xrg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  xrg_pkg::status_t status_i,
  output xrg_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX_A,
    S_MIX_B,
    S_MIX_END,
    S_ADV,
    S_MUL,
    S_BCHK,
    S_LIM_DIV,
    S_LIM_SET,
    S_CHECK,
    S_X_DIV,
    S_DONE
  } state_e;

  state_e                   state_q, state_d, ret_q, ret_d;
  logic [xrg_pkg::CNT_W-1:0] cnt_q, cnt_d;
  xrg_pkg::mul_const_e      mc_q, mc_d;
  logic [1:0]               action_q, action_d;
  logic                     bad_q, bad_d;
  logic                     out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    mc_d        = mc_q;
    action_d    = action_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    cmd_o            = '0;
    cmd_o.op         = xrg_pkg::OP_NONE;
    cmd_o.mc         = mc_q;
    cmd_o.mul_phase  = cnt_q[1:0];
    cmd_o.res_sel    = xrg_pkg::RES_ZERO;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_bound = 1'b1;
          action_d         = in_action_i;
          bad_d            = 1'b0;
          unique case (in_action_i) inside
            xrg_pkg::ACT_RESEED:                       state_d = S_MIX_A;
            xrg_pkg::ACT_RAW, xrg_pkg::ACT_UNIFORM:    state_d = S_ADV;
            default:                                   state_d = S_BCHK;
          endcase
        end
      end
      S_MIX_A: begin
        cmd_o.op = xrg_pkg::OP_MIX_A;
        mc_d     = xrg_pkg::MC_MIX_A;
        ret_d    = S_MIX_B;
        cnt_d    = '0;
        state_d  = S_MUL;
      end
      S_MIX_B: begin
        cmd_o.op = xrg_pkg::OP_MIX_B;
        mc_d     = xrg_pkg::MC_MIX_B;
        ret_d    = S_MIX_END;
        cnt_d    = '0;
        state_d  = S_MUL;
      end
      S_MIX_END: begin
        cmd_o.op = xrg_pkg::OP_MIX_END;
        state_d  = S_DONE;
      end
      S_ADV: begin
        cmd_o.op = xrg_pkg::OP_ADVANCE;
        mc_d     = xrg_pkg::MC_OUT;
        ret_d    = (action_q == xrg_pkg::ACT_BELOW) ? S_CHECK : S_DONE;
        cnt_d    = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = xrg_pkg::OP_MUL;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = ret_q;
        end
      end
      S_BCHK: begin
        if (status_i.bound_zero) begin
          bad_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.op = xrg_pkg::OP_DIV_LOAD_ONES;
          cnt_d    = '0;
          state_d  = S_LIM_DIV;
        end
      end
      S_LIM_DIV: begin
        cmd_o.op = xrg_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == xrg_pkg::CNT_LAST) begin
          state_d = S_LIM_SET;
        end
      end
      S_LIM_SET: begin
        cmd_o.op = xrg_pkg::OP_SET_LIMIT;
        state_d  = S_ADV;
      end
      S_CHECK: begin
        if (status_i.below_limit) begin
          cmd_o.op = xrg_pkg::OP_DIV_LOAD_ACC;
          cnt_d    = '0;
          state_d  = S_X_DIV;
        end else begin
          state_d = S_ADV;
        end
      end
      S_X_DIV: begin
        cmd_o.op = xrg_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == xrg_pkg::CNT_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.bad      = bad_q;
          unique case (action_q)
            xrg_pkg::ACT_RESEED:  cmd_o.res_sel = xrg_pkg::RES_ZERO;
            xrg_pkg::ACT_RAW:     cmd_o.res_sel = xrg_pkg::RES_RAW;
            xrg_pkg::ACT_UNIFORM: cmd_o.res_sel = xrg_pkg::RES_FRAC;
            default: cmd_o.res_sel = bad_q ? xrg_pkg::RES_ZERO : xrg_pkg::RES_REM;
          endcase
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      mc_q        <= xrg_pkg::MC_OUT;
      action_q    <= xrg_pkg::ACT_RESEED;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      mc_q        <= mc_d;
      action_q    <= action_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_mul_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> cnt_q[xrg_pkg::CNT_W-1:2] == '0)
    else $error("multiply phase counter out of range");

  a_reject_retries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK && !status_i.below_limit |=> state_q == S_ADV)
    else $error("rejected draw did not lead to a new draw");

  a_bad_only_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load && action_q != xrg_pkg::ACT_BELOW |-> !cmd_o.bad)
    else $error("bad bound flagged for an action without a bound");
`endif

endmodule

// File: sv/xorshift_random_generator.sv
// top level of the xorshift64* generator with splitmix64 reseeding
// reseed: mix A, multiply, mix B, multiply, mix end; raw or uniform draw: advance, multiply
// below bound: zero bound flagged at once, else limit division, advance, multiply, check per
// draw tried, remainder division; shared 32x32 multiplier, one-bit-per-cycle divider
// one item at a time, the next transfer taken in the cycle after the result register loads
// reset: async active low, seed back to 42, state to the splitmix64 mix of 42, no clearing pass
module xorshift_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_data_i,
  xrg_in_if.sink      in_i,
  xrg_out_if.source   out_o
);

  // command and status between sequencer and datapath
  xrg_pkg::cmd_t    cmd;
  xrg_pkg::status_t status;

  // sequencer: accepts a transfer in idle, steps the datapath, offers the result
  xrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_action_i (in_i.action),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: seed register, state, multiplier, divider and result register
  xrg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_bound_i  (in_i.bound),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_value_o (out_o.value),
    .out_bad_o   (out_o.bad_bound)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the xorshift64* generator with splitmix64 reseeding

module tb_top;

  // clocking, reset and run length
  localparam int unsigned     HALF_NS      = 4;
  localparam int unsigned     RESET_CYCLES = 7;
  localparam int unsigned     RAND_ITEMS   = 850;
  localparam int unsigned     BATCHES      = 8;
  localparam int unsigned     HOLD_CYCLES  = 600;
  localparam int unsigned     DRAIN_CYCLES = 200;
  localparam longint unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned     MAX_REPORTS  = 10;

  // generator arithmetic, kept apart from the design's own constants
  localparam logic [63:0] GOLD_INC   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL1    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL2    = 64'h94D049BB133111EB;
  localparam logic [63:0] STAR_MUL   = 64'h2545F4914F6CDD1D;
  localparam logic [63:0] BOOT_SEED  = 64'd42;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;
  // the one seed whose splitmix round gives zero, so the state is forced to one
  localparam logic [63:0] ZERO_MIX_SEED = 64'h61C8864680B583EB;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] bound;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic        bad;
  } draw_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_data_i;

  xrg_in_if  req_if ();
  xrg_out_if rsp_if ();

  xorshift_random_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // shadow copy of the seed register and the generator state
  logic [63:0] seed_q;
  logic [63:0] gen_q;

  // requests still to be offered, and results owed by the block in order
  req_t  req_backlog [$];
  draw_t draws_due [$];

  // idling controls, set by the stimulus process between batches
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;
  logic        pressure_go  = 1'b0;

  longint unsigned cycles = 0;

  // run statistics
  int unsigned n_reseed      = 0;
  int unsigned n_raw         = 0;
  int unsigned n_frac        = 0;
  int unsigned n_below       = 0;
  int unsigned n_bad         = 0;
  int unsigned n_reject      = 0;
  int unsigned n_seed_writes = 0;
  int unsigned n_checked     = 0;
  int unsigned n_fail        = 0;
  int unsigned n_shown       = 0;

  // one splitmix64 round, with the all-zero outcome pushed up to one
  function automatic logic [63:0] splitmix_round(input logic [63:0] v);
    logic [63:0] z;
    z = v + GOLD_INC;
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    z = z ^ (z >> 31);
    return (z == 64'd0) ? 64'd1 : z;
  endfunction

  // advance the shadow state by one xorshift and return the scrambled draw
  function automatic logic [63:0] step_xorshift();
    logic [63:0] x;
    x = gen_q;
    x ^= x >> 12;
    x ^= x << 25;
    x ^= x >> 27;
    gen_q = x;
    return x * STAR_MUL;
  endfunction

  // result owed for one accepted request; updates the shadow state
  function automatic draw_t gen_result(input req_t r);
    draw_t       d;
    logic [63:0] lim;
    logic [63:0] x;
    d = '0;
    case (r.action)
      xrg_pkg::ACT_RESEED: begin
        gen_q = splitmix_round(seed_q);
        n_reseed++;
      end
      xrg_pkg::ACT_RAW: begin
        d.value = step_xorshift();
        n_raw++;
      end
      xrg_pkg::ACT_UNIFORM: begin
        d.value = step_xorshift() >> 11;
        n_frac++;
      end
      xrg_pkg::ACT_BELOW: begin
        n_below++;
        if (r.bound == 64'd0) begin
          // zero bound: error flag, state untouched
          d.bad = 1'b1;
          n_bad++;
        end else begin
          // reject the uneven top slice so the remainder is unbiased
          lim = ALL_ONES - (ALL_ONES % r.bound);
          x = step_xorshift();
          while (x >= lim) begin
            n_reject++;
            x = step_xorshift();
          end
          d.value = x % r.bound;
        end
      end
    endcase
    return d;
  endfunction

  // random request: mostly draws, some reseeds, bounds spread over all magnitudes
  function automatic req_t rand_req();
    req_t        r;
    int unsigned pick;
    r.bound = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 8) r.action = xrg_pkg::ACT_RESEED;
    else if (pick < 30) r.action = xrg_pkg::ACT_RAW;
    else if (pick < 50) r.action = xrg_pkg::ACT_UNIFORM;
    else r.action = xrg_pkg::ACT_BELOW;
    if (r.action == xrg_pkg::ACT_BELOW) begin
      case ($urandom_range(7))
        0: r.bound = 64'd0;
        1: r.bound = 64'($urandom_range(16, 1));
        2: r.bound = 64'd1 << $urandom_range(63);
        3: r.bound = TOP_BIT | 64'($urandom_range(255));   // about half the draws rejected
        4: r.bound = ALL_ONES - 64'($urandom_range(255));
        5: r.bound = r.bound >> $urandom_range(63);
        default: ;
      endcase
    end
    return r;
  endfunction

  // clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #(HALF_NS);
    clk_i = 1'b1;
    #(HALF_NS);
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, draws_due.size());
      $display("** xorshift_random_generator: FAILED **");
      $finish;
    end
  end

  // request driver: predicts on every transfer, then offers the next item or idles
  always @(posedge clk_i) begin : drive_req
    req_t cur;
    req_t nxt;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        cur.action = req_if.action;
        cur.bound  = req_if.bound;
        draws_due.push_back(gen_result(cur));
      end
      if (req_if.valid && !req_if.ready) begin
        // item still on offer, hold it steady
      end else if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = req_backlog.pop_front();
        req_if.valid  <= 1'b1;
        req_if.action <= nxt.action;
        req_if.bound  <= nxt.bound;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor: every transfer is checked against the oldest owed result
  always @(posedge clk_i) begin : check_rsp
    draw_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (draws_due.size() == 0) begin
          n_fail++;
          if (n_shown < MAX_REPORTS) begin
            $display("%0t: result with nothing owed: value %h bad %b",
                     $realtime, rsp_if.value, rsp_if.bad_bound);
            n_shown++;
          end
        end else begin
          want = draws_due.pop_front();
          n_checked++;
          if (rsp_if.value !== want.value || rsp_if.bad_bound !== want.bad) begin
            n_fail++;
            if (n_shown < MAX_REPORTS) begin
              $display("%0t: mismatch: expected value %h bad %b, got value %h bad %b",
                       $realtime, want.value, want.bad, rsp_if.value, rsp_if.bad_bound);
              n_shown++;
            end
          end
        end
      end
      rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering, to back up the block
  initial begin : rx_holdoff
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // queue one request; called only just after a falling edge
  task automatic add_req(input logic [1:0] a, input logic [63:0] b);
    req_t r;
    r.action = a;
    r.bound  = b;
    req_backlog.push_back(r);
  endtask

  // wait until every request has been transferred and every result returned
  task automatic drain();
    while (req_backlog.size() != 0 || req_if.valid || draws_due.size() != 0)
      @(negedge clk_i);
  endtask

  // seed register write, only ever with the block idle
  task automatic write_seed(input logic [63:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seed_q = v;
    n_seed_writes++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    req_t        r;
    logic [63:0] s;
    int unsigned per_batch;

    // every block input known from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 64'd0;
    req_if.valid  = 1'b0;
    req_if.action = xrg_pkg::ACT_RESEED;
    req_if.bound  = 64'd0;
    rsp_if.ready  = 1'b0;

    // state after reset: seed 42 and its splitmix round
    seed_q = BOOT_SEED;
    gen_q  = splitmix_round(BOOT_SEED);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first draws straight from the reset state, bound extremes,
    // zero bound, bounds that force rejection, unused bound on other actions
    add_req(xrg_pkg::ACT_RAW, 64'd0);
    add_req(xrg_pkg::ACT_UNIFORM, ALL_ONES);
    add_req(xrg_pkg::ACT_BELOW, 64'd0);
    add_req(xrg_pkg::ACT_BELOW, 64'd1);
    add_req(xrg_pkg::ACT_BELOW, ALL_ONES);
    add_req(xrg_pkg::ACT_BELOW, TOP_BIT + 64'd1);
    add_req(xrg_pkg::ACT_BELOW, TOP_BIT);
    add_req(xrg_pkg::ACT_BELOW, 64'd10);
    add_req(xrg_pkg::ACT_RESEED, ALL_ONES);
    add_req(xrg_pkg::ACT_RAW, ALL_ONES);
    add_req(xrg_pkg::ACT_BELOW, 64'd3);

    // seed whose mix is zero: state must be forced to one
    write_seed(ZERO_MIX_SEED);
    add_req(xrg_pkg::ACT_RESEED, 64'd5);
    add_req(xrg_pkg::ACT_RAW, 64'd0);
    add_req(xrg_pkg::ACT_UNIFORM, 64'd0);
    add_req(xrg_pkg::ACT_BELOW, 64'd7);

    // seed extremes
    write_seed(ALL_ONES);
    add_req(xrg_pkg::ACT_RESEED, 64'd0);
    add_req(xrg_pkg::ACT_RAW, TOP_BIT);
    write_seed(64'd0);
    add_req(xrg_pkg::ACT_RESEED, TOP_BIT);
    add_req(xrg_pkg::ACT_UNIFORM, 64'd1);
    add_req(xrg_pkg::ACT_BELOW, 64'd0);
    add_req(xrg_pkg::ACT_BELOW, 64'd2);

    // random batches, each under its own idling mode and seed
    per_batch = RAND_ITEMS / BATCHES;
    for (int b = 0; b < BATCHES; b++) begin
      case (b % 5)
        0: s = {$urandom, $urandom};
        1: s = ZERO_MIX_SEED;
        2: s = ALL_ONES;
        3: s = 64'd0;
        default: s = BOOT_SEED;
      endcase
      write_seed(s);

      case (b % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 65;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 65;
        end
        default: begin
          tx_idle_pct  = 37;
          rx_stall_pct = 37;
        end
      endcase

      // open with a reseed so the fresh seed takes effect, then random traffic
      add_req(xrg_pkg::ACT_RESEED, {$urandom, $urandom});
      for (int i = 1; i < per_batch; i++) begin
        r = rand_req();
        add_req(r.action, r.bound);
      end
      if (b == 2) pressure_go = 1'b1;
      drain();
    end

    // settle, then make sure nothing extra turns up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (draws_due.size() != 0) begin
      $display("%0d results never returned", draws_due.size());
      n_fail += draws_due.size();
    end

    $display("run covered %0d reseeds, %0d raw, %0d fractions, %0d bounded draws",
             n_reseed, n_raw, n_frac, n_below);
    $display("  (%0d zero bounds, %0d rejected draws), %0d seed writes, %0d results checked",
             n_bad, n_reject, n_seed_writes, n_checked);
    if (n_fail == 0) begin
      $display("** xorshift_random_generator: PASSED **");
    end else begin
      $display("%0d failures", n_fail);
      $display("** xorshift_random_generator: FAILED **");
    end
    $finish;
  end

endmodule
